### rtl/core/wres_pkg.sv
// Package for the weighted random entry selector.
// Commands, status codes and controller states; no dependencies.
`default_nettype none
package wres_pkg;

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_PICK_WGT   = 3'd1,
        CMD_PICK_UNI   = 3'd2,
        CMD_MARK_FULL  = 3'd3,
        CMD_MARK_AVAIL = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_DUPLICATE   = 3'd1,
        ST_LIST_EMPTY  = 3'd2,
        ST_NOT_REG     = 3'd3,
        ST_ALREADY_AV  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_UNI,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_DONE
    } state_t;

    localparam int ID_BITS = 6;
    localparam int ID_DEPTH = 64;

endpackage
`default_nettype wire

### rtl/core/weighted_random_entry_selector.sv
// Top level of the weighted random entry selector (roulette wheel selection).
// Uses wres_pkg and two wres_ram instances (entry weights, available list).
//
// Channel  Dir  Ports                         Contents
// s_       in   s_tvalid s_tready s_tdata     tdata: entry_id[5:0] weight_value[21:6]
//                         s_tuser                    random_fraction[37:22]; tuser: command
// m_       out  m_tvalid m_tready m_tdata     tdata: chosen_id[5:0] available_count[12:6]
//                         m_tuser                    tuser: status
//
// Weighted pick: the walk reads one list entry per cycle through the list RAM
// then the weight RAM. Mark full: a scan finds the entry's list position, then
// a shift moves each later entry down one place (none when the entry is last).
// Reset: aresetn low, synchronous; flag vectors, length and total clear, no pass.
// Stalls: a new beat is taken while the previous result waits on m_; a result
// that finds m_ still occupied holds the controller until it drains.
`default_nettype none
module weighted_random_entry_selector #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // entry_id, weight_value, random_fraction
    input  wire logic [2:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // chosen_id, available_count
    output logic      [2:0]  m_tuser    // status
);
    import wres_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);          // list address
    localparam int LW = $clog2(MAX_ENTRIES + 1);      // list length
    localparam int CW = LW + 1;                       // walk counters, with headroom
    localparam int TW = WEIGHT_BITS + LW;             // total weight
    localparam logic [10:0] MAX_V = 11'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [2:0]             cmd_reg, cmd_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [15:0]            wt_reg, wt_next;
    logic [15:0]            rnd_reg, rnd_next;

    logic [LW-1:0]          len_reg, len_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [ID_DEPTH-1:0]    regd_reg, regd_next;
    logic [ID_DEPTH-1:0]    listed_reg, listed_next;

    logic [CW-1:0]          iss_reg, iss_next;
    logic [CW-1:0]          lidx_reg, lidx_next;
    logic [ID_BITS-1:0]     id1_reg, id1_next;
    logic [CW-1:0]          idx1_reg, idx1_next;
    logic                   v1_reg, v1_next;
    logic [TW+15:0]         target_reg, target_next;
    logic [TW-1:0]          accum_reg, accum_next;
    logic [ID_BITS-1:0]     pick_reg, pick_next;
    logic [LW-1:0]          shk_reg, shk_next;
    logic                   pend_reg, pend_next;
    logic [IW-1:0]          pend_addr_reg, pend_addr_next;

    logic [2:0]             res_status_reg, res_status_next;
    logic [ID_BITS-1:0]     res_chosen_reg, res_chosen_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [15:0]            m_tdata_reg, m_tdata_next;
    logic [2:0]             m_tuser_reg, m_tuser_next;

    // memory ports
    logic                   wt_we;
    logic [ID_BITS-1:0]     wt_raddr;
    logic [WEIGHT_BITS-1:0] wt_rdata;
    logic                   ls_we;
    logic [IW-1:0]          ls_waddr, ls_raddr;
    logic [ID_BITS-1:0]     ls_wdata, ls_rdata;

    logic                   in_range;
    logic [WEIGHT_BITS-1:0] new_wt;
    logic [LW+15:0]         uprod;
    logic [LW-1:0]          uidx;
    logic [LW-1:0]          shk_inc;
    logic                   shk_issue;

    wres_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ID_DEPTH)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (id_reg),
        .wdata (new_wt),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    wres_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_ENTRIES)) u_list_ram (
        .aclk  (aclk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    assign in_range  = {5'd0, id_reg} < MAX_V;
    assign new_wt    = WEIGHT_BITS'(wt_reg);
    assign uprod     = (LW+16)'(len_reg) * (LW+16)'(rnd_reg);
    assign uidx      = (uprod[LW+15:16] >= len_reg) ? LW'(len_reg - 1'b1) : uprod[LW+15:16];
    assign shk_inc   = LW'(shk_reg + 1'b1);
    assign shk_issue = shk_inc < len_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            total_reg    <= '0;
            regd_reg     <= '0;
            listed_reg   <= '0;
            v1_reg       <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            total_reg    <= total_next;
            regd_reg     <= regd_next;
            listed_reg   <= listed_next;
            v1_reg       <= v1_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        wt_reg         <= wt_next;
        rnd_reg        <= rnd_next;
        iss_reg        <= iss_next;
        lidx_reg       <= lidx_next;
        id1_reg        <= id1_next;
        idx1_reg       <= idx1_next;
        target_reg     <= target_next;
        accum_reg      <= accum_next;
        pick_reg       <= pick_next;
        shk_reg        <= shk_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_chosen_reg <= res_chosen_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        wt_next         = wt_reg;
        rnd_next        = rnd_reg;
        len_next        = len_reg;
        total_next      = total_reg;
        regd_next       = regd_reg;
        listed_next     = listed_reg;
        iss_next        = iss_reg;
        lidx_next       = lidx_reg;
        id1_next        = id1_reg;
        idx1_next       = idx1_reg;
        v1_next         = v1_reg;
        target_next     = target_reg;
        accum_next      = accum_reg;
        pick_next       = pick_reg;
        shk_next        = shk_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_chosen_next = res_chosen_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        wt_we    = 1'b0;
        wt_raddr = id_reg;
        ls_we    = 1'b0;
        ls_waddr = len_reg[IW-1:0];
        ls_wdata = id_reg;
        ls_raddr = iss_reg[IW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    id_next    = s_tdata[5:0];
                    wt_next    = s_tdata[21:6];
                    rnd_next   = s_tdata[37:22];
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_status_next = ST_OK;
                res_chosen_next = '0;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_REGISTER: begin
                        if (!in_range) begin
                            res_status_next = ST_NOT_REG;
                        end else if (regd_reg[id_reg]) begin
                            res_status_next = ST_DUPLICATE;
                        end else begin
                            wt_we             = 1'b1;
                            regd_next[id_reg] = 1'b1;
                            if (len_reg < LW'(MAX_ENTRIES)) begin
                                ls_we               = 1'b1;
                                listed_next[id_reg] = 1'b1;
                                len_next            = LW'(len_reg + 1'b1);
                                total_next          = total_reg + TW'(new_wt);
                            end
                        end
                    end
                    CMD_PICK_WGT: begin
                        if (len_reg == '0) begin
                            res_status_next = ST_LIST_EMPTY;
                        end else begin
                            target_next = (TW+16)'(total_reg) * (TW+16)'(rnd_reg);
                            ls_raddr    = '0;
                            lidx_next   = '0;
                            iss_next    = CW'(1);
                            v1_next     = 1'b0;
                            state_next  = S_WALK;
                        end
                    end
                    CMD_PICK_UNI: begin
                        if (len_reg == '0) begin
                            res_status_next = ST_LIST_EMPTY;
                        end else begin
                            ls_raddr   = uidx[IW-1:0];
                            state_next = S_UNI;
                        end
                    end
                    CMD_MARK_FULL: begin
                        if (!in_range || !regd_reg[id_reg]) begin
                            res_status_next = ST_NOT_REG;
                        end else if (listed_reg[id_reg]) begin
                            ls_raddr   = '0;
                            lidx_next  = '0;
                            iss_next   = CW'(1);
                            state_next = S_SCAN;
                        end
                    end
                    CMD_MARK_AVAIL: begin
                        if (!in_range || !regd_reg[id_reg]) begin
                            res_status_next = ST_NOT_REG;
                        end else if (listed_reg[id_reg]) begin
                            res_status_next = ST_ALREADY_AV;
                        end else begin
                            state_next = S_APPEND;
                        end
                    end
                    default: ;
                endcase
            end

            S_UNI: begin
                res_chosen_next = ls_rdata;
                state_next      = S_DONE;
            end

            S_APPEND: begin
                // weight of id_reg was read in the exec cycle
                if (len_reg < LW'(MAX_ENTRIES)) begin
                    ls_we               = 1'b1;
                    listed_next[id_reg] = 1'b1;
                    len_next            = LW'(len_reg + 1'b1);
                    total_next          = total_reg + TW'(wt_rdata);
                end
                state_next = S_DONE;
            end

            S_WALK: begin
                // issue -> list data -> weight data -> accumulate
                ls_raddr  = iss_reg[IW-1:0];
                lidx_next = iss_reg;
                iss_next  = CW'(iss_reg + 1'b1);
                wt_raddr  = ls_rdata;
                id1_next  = ls_rdata;
                idx1_next = lidx_reg;
                v1_next   = 1'b1;
                if (v1_reg) begin
                    if (idx1_reg == '0) begin
                        accum_next = TW'(wt_rdata);
                        pick_next  = id1_reg;
                        if (CW'(len_reg) == CW'(1)) begin
                            res_chosen_next = id1_reg;
                            state_next      = S_DONE;
                        end
                    end else if ({accum_reg, 16'd0} > target_reg) begin
                        res_chosen_next = pick_reg;
                        state_next      = S_DONE;
                    end else begin
                        accum_next = accum_reg + TW'(wt_rdata);
                        pick_next  = id1_reg;
                        if (CW'(idx1_reg + 1'b1) == CW'(len_reg)) begin
                            res_chosen_next = id1_reg;
                            state_next      = S_DONE;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (ls_rdata == id_reg) begin
                    shk_next   = lidx_reg[LW-1:0];
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end else begin
                    ls_raddr  = iss_reg[IW-1:0];
                    lidx_next = iss_reg;
                    iss_next  = CW'(iss_reg + 1'b1);
                end
            end

            S_SHIFT: begin
                // read k+1 now, write it to k in the next cycle
                ls_raddr = shk_inc[IW-1:0];
                if (pend_reg) begin
                    ls_we    = 1'b1;
                    ls_waddr = pend_addr_reg;
                    ls_wdata = ls_rdata;
                end
                pend_next      = shk_issue;
                pend_addr_next = shk_reg[IW-1:0];
                if (shk_issue) begin
                    shk_next = shk_inc;
                end
                if (!shk_issue && !pend_reg) begin
                    len_next            = LW'(len_reg - 1'b1);
                    total_next          = total_reg - TW'(wt_rdata);
                    listed_next[id_reg] = 1'b0;
                    state_next          = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {3'd0, 7'(len_reg), res_chosen_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // listed entries and length agree
    a_len_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(listed_reg) == int'(len_reg))
        else $error("list length differs from listed entries");

    a_listed_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        (listed_reg & ~regd_reg) == '0)
        else $error("listed entry not registered");

    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) |-> (total_reg == '0))
        else $error("empty list with nonzero total");

    a_shift_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && pend_reg) |-> (pend_addr_reg != shk_inc[IW-1:0]))
        else $error("shift write collides with read");

endmodule
`default_nettype wire

### rtl/core/wres_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module wres_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### dv/tb_weighted_random_entry_selector.sv
// Self-checking testbench for weighted_random_entry_selector.
// Depends on wres_pkg and the block's RTL; a scoreboard class predicts results.
`timescale 1ns / 100ps
`default_nettype none
module tb_weighted_random_entry_selector;
    import wres_pkg::*;

    // One predicted result beat.
    typedef struct packed {
        status_t    status;
        logic [5:0] chosen;
        logic [6:0] count;
    } sel_result_t;

    // Predictor of the entry list plus the queue of pending results.
    class selector_scoreboard;
        bit          reg_flag [64];
        logic [15:0] weight_of [64];
        logic [5:0]  avail [64];
        int          avail_len;
        logic [21:0] wheel_total = '0;
        sel_result_t pending [$];
        int          errors;

        function void note_beat(logic [2:0] cmd, logic [5:0] id, logic [15:0] wgt,
                                logic [15:0] frac);
            sel_result_t r;
            logic [37:0] target;
            logic [37:0] accum;
            int          pos;
            int          idx;
            bit          listed;
            r.status = ST_OK;
            r.chosen = '0;
            listed = 0;
            pos = -1;
            for (int i = 0; i < avail_len; i++)
                if (avail[i] == id && pos < 0) pos = i;
            listed = pos >= 0;
            case (cmd)
                CMD_REGISTER: begin
                    if (reg_flag[id]) begin
                        r.status = ST_DUPLICATE;
                    end else begin
                        reg_flag[id] = 1;
                        weight_of[id] = wgt;
                        add_entry(id);
                    end
                end
                CMD_PICK_WGT: begin
                    if (avail_len == 0) begin
                        r.status = ST_LIST_EMPTY;
                    end else begin
                        // First entry whose inclusive prefix exceeds total*r.
                        target = wheel_total * frac;
                        r.chosen = avail[0];
                        accum = weight_of[avail[0]];
                        for (int i = 1; i < avail_len; i++) begin
                            if ((accum << 16) > target) break;
                            r.chosen = avail[i];
                            accum += weight_of[avail[i]];
                        end
                    end
                end
                CMD_PICK_UNI: begin
                    if (avail_len == 0) begin
                        r.status = ST_LIST_EMPTY;
                    end else begin
                        idx = (avail_len * frac) >> 16;
                        if (idx >= avail_len) idx = avail_len - 1;
                        r.chosen = avail[idx];
                    end
                end
                CMD_MARK_FULL: begin
                    if (!reg_flag[id]) begin
                        r.status = ST_NOT_REG;
                    end else if (listed) begin
                        wheel_total -= weight_of[id];
                        for (int k = pos; k + 1 < avail_len; k++) avail[k] = avail[k + 1];
                        avail_len--;
                    end
                end
                CMD_MARK_AVAIL: begin
                    if (!reg_flag[id]) r.status = ST_NOT_REG;
                    else if (listed) r.status = ST_ALREADY_AV;
                    else add_entry(id);
                end
                default: ;
            endcase
            r.count = avail_len[6:0];
            pending = {pending, r};
        endfunction

        function void add_entry(logic [5:0] id);
            if (avail_len >= 64) return;
            avail[avail_len] = id;
            avail_len++;
            wheel_total += weight_of[id];
        endfunction

        function void check_beat(logic [2:0] st, logic [5:0] chosen, logic [6:0] cnt);
            sel_result_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (chosen !== e.chosen) begin
                $error("chosen_id: expected %0d actual %0d", e.chosen, chosen);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("available_count: expected %0d actual %0d", e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    selector_scoreboard sb = new();
    bit  calm;              // no idling in the last part of the run
    int  idle_cycles = 0;   // watchdog: cycles with no beat on either side

    localparam int WATCHDOG_LIMIT = 5000;

    always #5 aclk = ~aclk;

    weighted_random_entry_selector uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Result side: check every beat, back-pressure in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tuser, m_tdata[5:0], m_tdata[12:6]);
    end

    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                stall = $urandom_range(1, 10);
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one command beat and wait for its acceptance.
    task automatic send_cmd(logic [2:0] cmd, logic [5:0] id, logic [15:0] wgt,
                            logic [15:0] frac);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, frac, wgt, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(cmd, id, wgt, frac);
    endtask

    // Random id, biased to a small pool so marks mostly hit registered entries.
    function automatic logic [5:0] pick_id();
        return ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
    endfunction

    initial begin
        logic [2:0] cmd;
        calm = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty-list picks, unregistered marks, extremes, duplicates, undefined commands.
        send_cmd(CMD_PICK_WGT, 0, 0, 16'hFFFF);
        send_cmd(CMD_PICK_UNI, 0, 0, 0);
        send_cmd(CMD_MARK_FULL, 63, 0, 0);
        send_cmd(CMD_MARK_AVAIL, 5, 0, 0);
        send_cmd(CMD_REGISTER, 0, 16'hFFFF, 0);
        send_cmd(CMD_REGISTER, 63, 0, 16'hFFFF);
        send_cmd(CMD_REGISTER, 0, 1, 0);
        send_cmd(CMD_REGISTER, 21, 16'h5555, 16'hAAAA);
        send_cmd(CMD_REGISTER, 42, 16'hAAAA, 16'h5555);
        send_cmd(CMD_PICK_WGT, 0, 0, 0);
        send_cmd(CMD_PICK_WGT, 0, 0, 16'hFFFF);
        send_cmd(CMD_PICK_WGT, 0, 0, 16'h8000);
        send_cmd(CMD_PICK_UNI, 0, 0, 16'hFFFF);
        send_cmd(CMD_MARK_AVAIL, 21, 0, 0);
        send_cmd(CMD_MARK_FULL, 21, 0, 0);
        send_cmd(CMD_MARK_FULL, 21, 0, 0);
        send_cmd(CMD_MARK_AVAIL, 21, 0, 0);
        send_cmd(3'd5, 6'h2A, 16'h1234, 16'h4321);
        send_cmd(3'd7, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_cmd(CMD_MARK_FULL, (i == 0) ? 0 : (i == 1) ? 63 :
                                             (i == 2) ? 21 : 42, 0, 0);
        send_cmd(CMD_PICK_WGT, 0, 0, 16'h1234);

        // Random: a mixed workload, with a run of beats that registers every id in turn.
        for (int n = 0; n < 500; n++) begin
            if (n == 250) begin
                // Sender holds off until the result queue drains.
                s_tvalid <= 0;
                while (sb.pending.size() != 0) @(posedge aclk);
            end
            if (n >= 420) calm = 1;
            if (n >= 100 && n < 170) begin
                send_cmd(CMD_REGISTER, 6'(n - 100), 16'($urandom), 16'($urandom));
                continue;
            end
            case ($urandom_range(0, 9))
                0, 1:    cmd = CMD_REGISTER;
                2, 3, 4: cmd = CMD_PICK_WGT;
                5, 6:    cmd = CMD_PICK_UNI;
                7:       cmd = CMD_MARK_FULL;
                8:       cmd = CMD_MARK_AVAIL;
                default: cmd = 3'($urandom_range(0, 7));
            endcase
            send_cmd(cmd, (n < 100 || n >= 300) ? pick_id() : 6'($urandom),
                     16'($urandom), 16'($urandom));
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
